// ===== design/rarl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rarl_pkg
// Shared types and codes of the reconnect attempt rate limiter.
// ----------------------------------------------------------------------------
package rarl_pkg;

  // request function codes
  localparam logic FUNC_ATTEMPT = 1'b0;
  localparam logic FUNC_DROP    = 1'b1;

  // result status codes
  localparam int unsigned STATUS_W = 3;
  localparam logic [STATUS_W-1:0] STATUS_ADMIT       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_COOLDOWN    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_WINDOW_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED     = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 1'd1;

  localparam int unsigned INTERVAL_W      = 32;
  localparam int unsigned COUNT_W         = 8;
  localparam int unsigned REFUSE_W        = 32;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [COUNT_W-1:0]    MAX_RESET      = 8'd8;

  // result packing
  localparam int unsigned OUT_W       = STATUS_W + 1 + REFUSE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_W;

  // table scan outcome
  typedef struct packed {
    logic done;
    logic found;
    logic has_free;
  } scan_t;

  // table write-back control
  typedef struct packed {
    logic we;
    logic set_valid;
    logic adm;
  } wr_t;

endpackage
`default_nettype wire

// ===== design/rarl_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rarl_table
// Per-connection table: entry memory, valid bits and a linear lookup scan.
// ----------------------------------------------------------------------------
module rarl_table #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned CONN_ID_BITS  = 16,
  parameter int unsigned TIME_BITS     = 48,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire                     drop_i,
  input  wire [CONN_ID_BITS-1:0]  conn_i,
  input  rarl_pkg::wr_t           wr_i,
  input  wire [IDX_W-1:0]         wr_slot_i,
  input  wire [TIME_BITS-1:0]     wr_time_i,
  output rarl_pkg::scan_t         scan_o,
  output logic [IDX_W-1:0]        slot_o,
  output logic [IDX_W-1:0]        free_slot_o,
  output logic                    adm_o,
  output logic [TIME_BITS-1:0]    last_o
);

  localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTRY_W = CONN_ID_BITS + TIME_BITS + 1;

  logic [ENTRY_W-1:0]       mem_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]       rd_data_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q;
  logic                     rd_pend_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     found_q;
  logic                     free_q;

  logic                    issue;
  logic                    hit;
  logic [CONN_ID_BITS-1:0] rd_conn;
  logic [TIME_BITS-1:0]    rd_time;
  logic                    rd_adm;

  assign issue   = busy_q && (cnt_q != CNT_W'(TABLE_ENTRIES));
  assign rd_conn = rd_data_q[CONN_ID_BITS-1:0];
  assign rd_time = rd_data_q[CONN_ID_BITS+TIME_BITS-1:CONN_ID_BITS];
  assign rd_adm  = rd_data_q[ENTRY_W-1];
  assign hit     = rd_pend_q && valid_q[rd_idx_q] && (rd_conn == conn_i);

  assign scan_o.done     = busy_q && !issue && !rd_pend_q;
  assign scan_o.found    = found_q;
  assign scan_o.has_free = free_q;

  // entry memory, writes only come after a scan has finished
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_slot_i] <= {wr_i.adm, wr_time_i, conn_i};
    end
    if (issue) begin
      rd_data_q <= mem_q[cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (scan_o.done) begin
        busy_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      rd_pend_q <= issue && !start_i;
      rd_idx_q  <= cnt_q[IDX_W-1:0];
      if (hit && drop_i) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (hit && !drop_i && !found_q) begin
        found_q <= 1'b1;
      end
      if (rd_pend_q && !valid_q[rd_idx_q] && !free_q) begin
        free_q <= 1'b1;
      end
      if (wr_i.we && wr_i.set_valid) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
    end
  end

  // hit payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (hit && !drop_i && !found_q) begin
      slot_o <= rd_idx_q;
      adm_o  <= rd_adm;
      last_o <= rd_time;
    end
    if (rd_pend_q && !valid_q[rd_idx_q] && !free_q) begin
      free_slot_o <= rd_idx_q;
    end
  end

  a_found_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_o.done && found_q && !drop_i) |-> valid_q[slot_o])
    else $error("found slot not valid");

endmodule
`default_nettype wire

// ===== design/reconnect_attempt_rate_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// reconnect_attempt_rate_limiter
// Admits or refuses reconnect attempts with a global fixed window and a
// per-connection cooldown; drop requests free a connection's table entry.
// ----------------------------------------------------------------------------
// flow: an accepted request starts a linear scan of the entry memory, one entry
//   per cycle; once the scan is done and the output is free, the result is
//   decided and registered, and only then is a new request taken
// a new request is taken while the previous result still waits on the output
// reset: window closed, table empty, counters zero, interval 1000, max 8;
//   no clearing pass, the table is usable straight after reset
module reconnect_attempt_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned CONN_ID_BITS  = 16,
  parameter int unsigned TIME_BITS     = 48,
  localparam int unsigned IN_W       = CONN_ID_BITS + TIME_BITS,
  localparam int unsigned S_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire [S_TDATA_W-1:0]                  s_axis_tdata,  // connection_id, now_ms
  input  wire                                  s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [rarl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // status, admitted, refused_total
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [rarl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [rarl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CMP_W = (TIME_BITS > rarl_pkg::INTERVAL_W) ? TIME_BITS
                                                                     : rarl_pkg::INTERVAL_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [rarl_pkg::INTERVAL_W-1:0] interval_q;
  logic [rarl_pkg::COUNT_W-1:0]    max_q;
  logic [TIME_BITS-1:0]            win_start_q;
  logic [rarl_pkg::COUNT_W-1:0]    win_cnt_q;
  logic                            win_open_q;
  logic                            win_pend_q;
  logic [rarl_pkg::REFUSE_W-1:0]   refusal_q;

  logic                    drop_q;
  logic [CONN_ID_BITS-1:0] conn_q;
  logic [TIME_BITS-1:0]    now_q;

  logic                              out_valid_q;
  logic [rarl_pkg::STATUS_W-1:0]     out_status_q;
  logic                              out_adm_q;
  logic [rarl_pkg::REFUSE_W-1:0]     out_refused_q;

  rarl_pkg::scan_t      scan;
  rarl_pkg::wr_t        wr;
  logic [IDX_W-1:0]     hit_slot;
  logic [IDX_W-1:0]     free_slot;
  logic                 hit_adm;
  logic [TIME_BITS-1:0] hit_last;

  logic                  accept;
  logic                  out_free;
  logic                  decide;
  logic [TIME_BITS-1:0]  win_diff;
  logic                  restart;
  logic [TIME_BITS-1:0]  cool_diff;
  logic                  cool;
  logic [rarl_pkg::STATUS_W-1:0] status;
  logic                  refuse;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign decide        = (state_q == ST_DECIDE) && out_free;
  assign cfg_ready_o   = 1'b1;

  // window restart check
  assign win_diff = now_q - win_start_q;
  assign restart  = !win_open_q || (now_q < win_start_q) ||
                    (CMP_W'(win_diff) >= CMP_W'(interval_q));

  // cooldown check and decision
  assign cool_diff = now_q - hit_last;
  assign cool      = scan.found && hit_adm && (now_q >= hit_last) &&
                     (CMP_W'(cool_diff) < CMP_W'(interval_q));

  always_comb begin
    if (drop_q) begin
      status = rarl_pkg::STATUS_DROPPED;
    end else if (!scan.found && !scan.has_free) begin
      status = rarl_pkg::STATUS_TABLE_FULL;
    end else if (cool) begin
      status = rarl_pkg::STATUS_COOLDOWN;
    end else if (win_cnt_q >= max_q) begin
      status = rarl_pkg::STATUS_WINDOW_FULL;
    end else begin
      status = rarl_pkg::STATUS_ADMIT;
    end
  end

  assign refuse = (status == rarl_pkg::STATUS_COOLDOWN) ||
                  (status == rarl_pkg::STATUS_WINDOW_FULL);

  always_comb begin
    wr.adm       = (status == rarl_pkg::STATUS_ADMIT);
    wr.set_valid = !scan.found;
    wr.we        = decide && !drop_q && (status != rarl_pkg::STATUS_TABLE_FULL) &&
                   (!scan.found || wr.adm);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interval_q  <= rarl_pkg::INTERVAL_RESET;
      max_q       <= rarl_pkg::MAX_RESET;
      win_start_q <= '0;
      win_cnt_q   <= '0;
      win_open_q  <= 1'b0;
      win_pend_q  <= 1'b0;
      refusal_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rarl_pkg::REG_INTERVAL: interval_q <= cfg_data_i;
          rarl_pkg::REG_MAX:      max_q      <= cfg_data_i[rarl_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        win_pend_q <= (s_axis_tuser == rarl_pkg::FUNC_ATTEMPT);
      end else if (win_pend_q) begin
        win_pend_q <= 1'b0;
        if (restart) begin
          win_start_q <= now_q;
          win_cnt_q   <= '0;
          win_open_q  <= 1'b1;
        end
      end
      if (decide) begin
        if (status == rarl_pkg::STATUS_ADMIT) begin
          win_cnt_q <= win_cnt_q + rarl_pkg::COUNT_W'(1);
        end
        if (refuse && (refusal_q != '1)) begin
          refusal_q <= refusal_q + rarl_pkg::REFUSE_W'(1);
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      drop_q <= (s_axis_tuser == rarl_pkg::FUNC_DROP);
      conn_q <= s_axis_tdata[CONN_ID_BITS-1:0];
      now_q  <= s_axis_tdata[IN_W-1:CONN_ID_BITS];
    end
    if (decide) begin
      out_status_q  <= status;
      out_adm_q     <= (status == rarl_pkg::STATUS_ADMIT);
      out_refused_q <= (refuse && (refusal_q != '1)) ? refusal_q + rarl_pkg::REFUSE_W'(1)
                                                     : refusal_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{rarl_pkg::OUT_PAD_W{1'b0}}, out_refused_q, out_adm_q, out_status_q};

  rarl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CONN_ID_BITS  (CONN_ID_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .drop_i      (drop_q),
    .conn_i      (conn_q),
    .wr_i        (wr),
    .wr_slot_i   (scan.found ? hit_slot : free_slot),
    .wr_time_i   (now_q),
    .scan_o      (scan),
    .slot_o      (hit_slot),
    .free_slot_o (free_slot),
    .adm_o       (hit_adm),
    .last_o      (hit_last)
  );

  a_refusal_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refusal_q >= $past(refusal_q))
    else $error("refusal count went down");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan.done |-> (state_q == ST_SCAN))
    else $error("scan finished outside scan state");

  a_adm_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_adm_q == (out_status_q == rarl_pkg::STATUS_ADMIT)))
    else $error("admitted flag disagrees with status");

  a_window_after_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && !drop_q) |-> win_open_q)
    else $error("attempt decided with window closed");

endmodule
`default_nettype wire
